// ===== src/gda_pkg.sv =====
// Shared types, constants and calendar helpers for the Gregorian date advance unit.
// No dependencies; imported by gda_sub_unit and gregorian_date_advance_unit.
package gda_pkg;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int COUNT_W = 16;
    localparam int R400_W  = 9;
    localparam int R100_W  = 7;

    localparam logic [YEAR_W-1:0]  MAX_YEAR   = 14'd9999;
    localparam logic [YEAR_W-1:0]  MOD_400    = 14'd400;
    localparam logic [YEAR_W-1:0]  MOD_100    = 14'd100;
    localparam logic [R400_W-1:0]  R400_LAST  = 9'd399;
    localparam logic [R100_W-1:0]  R100_LAST  = 7'd99;
    localparam logic [MONTH_W-1:0] MONTH_JAN  = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB  = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_APR  = 4'd4;
    localparam logic [MONTH_W-1:0] MONTH_JUN  = 4'd6;
    localparam logic [MONTH_W-1:0] MONTH_SEP  = 4'd9;
    localparam logic [MONTH_W-1:0] MONTH_NOV  = 4'd11;
    localparam logic [MONTH_W-1:0] MONTH_DEC  = 4'd12;
    localparam logic [DAY_W-1:0]   DAY_FIRST  = 5'd1;
    localparam logic [DAY_W-1:0]   DAY_LAST31 = 5'd31;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_BAD_DATE   = 2'd1,
        ST_ZERO_COUNT = 2'd2,
        ST_OVERFLOW   = 2'd3
    } status_t;

    typedef struct packed {
        logic [YEAR_W-1:0]  start_year;
        logic [MONTH_W-1:0] start_month;
        logic [DAY_W-1:0]   start_day;
        logic [COUNT_W-1:0] day_count;
    } req_t;

    typedef struct packed {
        logic [YEAR_W-1:0]  end_year;
        logic [MONTH_W-1:0] end_month;
        logic [DAY_W-1:0]   end_day;
        status_t            status;
    } rsp_t;

    // Result of the shared compare and subtract unit.
    typedef struct packed {
        logic              ge;
        logic [YEAR_W-1:0] diff;
    } sub_res_t;

    // Days in a month; months outside 1..12 fall to 31 and are rejected elsewhere.
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                    input logic leap);
        logic [DAY_W-1:0] len;
        len = 5'd31;
        case (m)
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
            MONTH_FEB: len = leap ? 5'd29 : 5'd28;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

// ===== src/gda_sub_unit.sv =====
// Shared compare and subtract unit used to reduce the year modulo 400 and 100.
// Depends on gda_pkg.
module gda_sub_unit (
    input  logic [gda_pkg::YEAR_W-1:0] a,
    input  logic [gda_pkg::YEAR_W-1:0] b,
    output gda_pkg::sub_res_t          res
);
    import gda_pkg::*;

    logic [YEAR_W:0] wide_diff;

    // One subtraction; the borrow bit gives the compare result.
    always_comb
    begin
        wide_diff = {1'b0, a} - {1'b0, b};
        res.ge    = ~wide_diff[YEAR_W];
        res.diff  = wide_diff[YEAR_W-1:0];
    end

endmodule

// ===== src/gregorian_date_advance_unit.sv =====
// Top level of the Gregorian date advance unit: sequencer, date registers and result.
// Depends on gda_pkg and gda_sub_unit.
//
// Usage: drive req with a start date and a day count and raise start while busy is
// low; that edge accepts the transaction and busy is high from the next cycle on. The
// block first reduces the year modulo 400 and then modulo 100 by repeated subtraction
// in one shared subtract unit, checks the date, then advances one day per cycle until
// the count is used up and returns the result. A year overflow ends the loop early,
// and an invalid date or a zero count ends the transaction after the check. A start
// year above 9999 is rejected in the first reduction step, ahead of any subtraction.
// The result appears on rsp, marked by done high for a single cycle, in the first cycle
// that busy is low again; the receiver cannot stall, so it must take the result then.
// A new transaction may be started in the done cycle itself. Only one transaction is
// in flight at a time.
// Reset (rst_n low, asynchronous) returns the sequencer to idle and clears done;
// no result is produced for a transaction cut off by reset.
module gregorian_date_advance_unit #(
    parameter int unsigned MAX_COUNT = 65535
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  gda_pkg::req_t req,
    output logic          busy,
    output logic          done,
    output gda_pkg::rsp_t rsp
);
    import gda_pkg::*;

    localparam logic [31:0] MAX_CNT = 32'(MAX_COUNT);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_MOD400 = 5'b00010,
        S_MOD100 = 5'b00100,
        S_CHECK  = 5'b01000,
        S_RUN    = 5'b10000
    } state_t;

    state_t              state_reg, state_next;
    logic [YEAR_W-1:0]   year_reg, year_next;
    logic [MONTH_W-1:0]  month_reg, month_next;
    logic [DAY_W-1:0]    day_reg, day_next;
    logic [COUNT_W-1:0]  cnt_reg, cnt_next;
    logic [YEAR_W-1:0]   rem_reg, rem_next;
    logic [R400_W-1:0]   r400_reg, r400_next;
    logic [R100_W-1:0]   r100_reg, r100_next;
    logic                done_reg, done_next;
    rsp_t                rsp_reg, rsp_next;

    logic [YEAR_W-1:0]   sub_b;
    sub_res_t            sub_res;
    logic                leap;
    logic [DAY_W-1:0]    mlen;
    logic                date_ok;

    // Shared subtract unit; the modulus follows the reduction step.
    assign sub_b = state_reg == S_MOD100 ? MOD_100 : MOD_400;

    gda_sub_unit u_sub (
        .a   (rem_reg),
        .b   (sub_b),
        .res (sub_res)
    );

    // Leap year from the running residues and the low year bits.
    assign leap = ((year_reg[1:0] == 2'd0) && (r100_reg != '0)) || (r400_reg == '0);
    assign mlen = month_len(month_reg, leap);
    assign date_ok = (month_reg >= MONTH_JAN) && (month_reg <= MONTH_DEC)
                     && (day_reg != '0) && (day_reg <= mlen);

    // Sequencer and datapath next state.
    always_comb
    begin
        state_next = state_reg;
        year_next  = year_reg;
        month_next = month_reg;
        day_next   = day_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        r400_next  = r400_reg;
        r100_next  = r100_reg;
        done_next  = 1'b0;
        rsp_next   = rsp_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    year_next  = req.start_year;
                    month_next = req.start_month;
                    day_next   = req.start_day;
                    rem_next   = req.start_year;
                    cnt_next   = (32'(req.day_count) > MAX_CNT) ? MAX_CNT[COUNT_W-1:0]
                                                                : req.day_count;
                    state_next = S_MOD400;
                end
            end
            S_MOD400:
            begin
                if (year_reg > MAX_YEAR)
                begin
                    rsp_next   = '{end_year: '0, end_month: '0, end_day: '0,
                                   status: ST_BAD_DATE};
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else if (sub_res.ge)
                begin
                    rem_next = sub_res.diff;
                end
                else
                begin
                    r400_next  = rem_reg[R400_W-1:0];
                    state_next = S_MOD100;
                end
            end
            S_MOD100:
            begin
                if (sub_res.ge)
                begin
                    rem_next = sub_res.diff;
                end
                else
                begin
                    r100_next  = rem_reg[R100_W-1:0];
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (!date_ok)
                begin
                    rsp_next   = '{end_year: '0, end_month: '0, end_day: '0,
                                   status: ST_BAD_DATE};
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else if (cnt_reg == '0)
                begin
                    rsp_next   = '{end_year: year_reg, end_month: month_reg,
                                   end_day: day_reg, status: ST_ZERO_COUNT};
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                if (cnt_reg == '0)
                begin
                    rsp_next   = '{end_year: year_reg, end_month: month_reg,
                                   end_day: day_reg, status: ST_OK};
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else if (day_reg < mlen)
                begin
                    day_next = day_reg + DAY_FIRST;
                    cnt_next = cnt_reg - 16'd1;
                end
                else if (month_reg != MONTH_DEC)
                begin
                    day_next   = DAY_FIRST;
                    month_next = month_reg + MONTH_JAN;
                    cnt_next   = cnt_reg - 16'd1;
                end
                else if (year_reg >= MAX_YEAR)
                begin
                    rsp_next   = '{end_year: MAX_YEAR, end_month: MONTH_DEC,
                                   end_day: DAY_LAST31, status: ST_OVERFLOW};
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    // New year: keep the residues in step with the year.
                    day_next   = DAY_FIRST;
                    month_next = MONTH_JAN;
                    year_next  = year_reg + 14'd1;
                    r400_next  = (r400_reg == R400_LAST) ? '0 : r400_reg + 9'd1;
                    r100_next  = (r100_reg == R100_LAST) ? '0 : r100_reg + 7'd1;
                    cnt_next   = cnt_reg - 16'd1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        year_reg  <= year_next;
        month_reg <= month_next;
        day_reg   <= day_next;
        cnt_reg   <= cnt_next;
        rem_reg   <= rem_next;
        r400_reg  <= r400_next;
        r100_reg  <= r100_next;
        rsp_reg   <= rsp_next;
    end

    assign busy = state_reg != S_IDLE;
    assign done = done_reg;
    assign rsp  = rsp_reg;

    // A result strobe only follows a transaction that was in progress.
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("done without a transaction in progress");

    // The result strobe lasts one cycle.
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held longer than one cycle");

    // An accepted transaction makes the block busy.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted transaction did not raise busy");

    // A successful result has a month in 1..12, a nonzero day and a year up to 9999.
    a_ok_date: assert property (@(posedge clk) disable iff (!rst_n)
        done && rsp.status == ST_OK |-> rsp.end_month >= MONTH_JAN
            && rsp.end_month <= MONTH_DEC && rsp.end_day != '0
            && rsp.end_year <= MAX_YEAR)
        else $error("ok result carries an impossible date");

    // The year residues stay in range while days are advanced.
    a_residue_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_RUN |-> r400_reg <= R400_LAST && r100_reg <= R100_LAST)
        else $error("year residue out of range");

endmodule
